/* hdl/lfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared types and constants of the link frame deframer.
// ----------------------------------------------------------------------------
package lfd_pkg;

	typedef enum logic [1:0] {
		PH_OUTER   = 2'd0,
		PH_INNER   = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef logic [2:0] ev_t;

	localparam ev_t EV_CFG     = 3'd0;
	localparam ev_t EV_PKG     = 3'd1;
	localparam ev_t EV_NEG     = 3'd2;
	localparam ev_t EV_DROP    = 3'd3;
	localparam ev_t EV_UNKNOWN = 3'd4;
	localparam ev_t EV_BADLEN  = 3'd5;

	localparam logic [1:0] KIND_PKG = 2'd0;
	localparam logic [1:0] KIND_CFG = 2'd1;
	localparam logic [1:0] KIND_NEG = 2'd2;
	localparam logic [1:0] KIND_UNK = 2'd3;

	// outer header byte positions
	localparam logic [3:0] LEN_B0_IDX = 4'd12;
	localparam logic [3:0] LEN_B1_IDX = 4'd13;
	localparam logic [3:0] LEN_B2_IDX = 4'd14;
	localparam logic [3:0] LEN_B3_IDX = 4'd15;

	localparam logic [10:0] MIN_PAYLOAD_LEN = 11'd2;
	localparam logic [10:0] MAX_LEN_RESET   = 11'd2032;

	typedef struct packed {
		ev_t         ev;
		logic [7:0]  payload;
		logic        last;
		logic        ack2;
		logic        pass;
		logic [6:0]  reason;
		logic [13:0] ilen;
	} res_t;

endpackage
`default_nettype wire

/* hdl/lfd_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfd_core
// Frame parser: state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module lfd_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    data_byte,
	input  wire logic [10:0]   max_len,
	output logic               res_valid,
	output lfd_pkg::res_t      res
);
	import lfd_pkg::*;

	phase_t      phase_q, phase_nxt;
	logic [3:0]  byte_idx_q, byte_idx_nxt;
	logic [10:0] len_lo_q, len_lo_nxt;
	logic        len_hi_q, len_hi_nxt;
	logic [10:0] remain_q, remain_nxt;
	logic [1:0]  kind_q, kind_nxt;
	logic [7:0]  inner_b0_q, inner_b0_nxt;
	logic [7:0]  neg_b0_q, neg_b0_nxt;
	logic        cfg_pend_q, cfg_pend_nxt;
	logic        fwd_q, fwd_nxt;

	logic [1:0]  hdr_kind;
	logic [13:0] ilen;
	logic [10:0] rem_hdr;
	logic [10:0] rem_pay;
	logic        fin;
	logic        bad_len;

	function automatic res_t neg_result(input logic [7:0] b0, input logic [7:0] b1);
		res_t r;
		r = '0;
		r.ev     = EV_NEG;
		r.ack2   = b0[6];
		r.pass   = b0[6] & b1[7];
		r.reason = b0[6] ? b1[6:0] : 7'd0;
		return r;
	endfunction

	assign hdr_kind = inner_b0_q[7:6];
	assign ilen     = {inner_b0_q[5:0], data_byte};
	assign rem_hdr  = remain_q - 11'd2;
	assign rem_pay  = remain_q - 11'd1;
	assign fin      = (rem_pay == 11'd0);

	// length bytes 12..15, little endian; only 11 bits are kept, the rest is an
	// any-nonzero flag
	always_comb begin
		len_lo_nxt = len_lo_q;
		len_hi_nxt = len_hi_q;
		case (byte_idx_q)
			LEN_B0_IDX: len_lo_nxt[7:0] = data_byte;
			LEN_B1_IDX: begin
				len_lo_nxt[10:8] = data_byte[2:0];
				len_hi_nxt       = |data_byte[7:3];
			end
			LEN_B2_IDX, LEN_B3_IDX: len_hi_nxt = len_hi_q | (|data_byte);
			default: ;
		endcase
	end

	assign bad_len = len_hi_nxt || (len_lo_nxt < MIN_PAYLOAD_LEN) || (len_lo_nxt > max_len);

	// next state
	always_comb begin
		phase_nxt    = phase_q;
		byte_idx_nxt = byte_idx_q;
		remain_nxt   = remain_q;
		kind_nxt     = kind_q;
		inner_b0_nxt = inner_b0_q;
		neg_b0_nxt   = neg_b0_q;
		cfg_pend_nxt = cfg_pend_q;
		fwd_nxt      = fwd_q;
		case (phase_q)
			PH_OUTER: begin
				byte_idx_nxt = byte_idx_q + 4'd1;
				if (byte_idx_q == LEN_B3_IDX && !bad_len) begin
					remain_nxt = len_lo_nxt;
					phase_nxt  = PH_INNER;
				end
			end
			PH_INNER: begin
				if (byte_idx_q == 4'd0) begin
					inner_b0_nxt = data_byte;
					byte_idx_nxt = 4'd1;
				end else begin
					remain_nxt   = rem_hdr;
					kind_nxt     = hdr_kind;
					byte_idx_nxt = 4'd0;
					phase_nxt    = (rem_hdr == 11'd0) ? PH_OUTER : PH_PAYLOAD;
					fwd_nxt      = 1'b0;
					if (hdr_kind == KIND_CFG) begin
						fwd_nxt      = 1'b1;
						cfg_pend_nxt = 1'b1;
					end else if (hdr_kind == KIND_PKG && cfg_pend_q) begin
						fwd_nxt      = 1'b1;
						cfg_pend_nxt = 1'b0;
					end
				end
			end
			PH_PAYLOAD: begin
				remain_nxt = rem_pay;
				if (!fwd_q && kind_q == KIND_NEG && byte_idx_q < 4'd2) begin
					if (byte_idx_q == 4'd0) begin
						neg_b0_nxt   = data_byte;
						byte_idx_nxt = 4'd1;
					end else begin
						byte_idx_nxt = 4'd2;
					end
				end
				if (fin) begin
					phase_nxt    = PH_OUTER;
					byte_idx_nxt = 4'd0;
				end
			end
			default: begin
				phase_nxt    = PH_OUTER;
				byte_idx_nxt = 4'd0;
			end
		endcase
	end

	// result
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_OUTER: begin
				if (byte_idx_q == LEN_B3_IDX && bad_len) begin
					res_valid = 1'b1;
					res.ev    = EV_BADLEN;
				end
			end
			PH_INNER: begin
				if (byte_idx_q != 4'd0) begin
					if (hdr_kind == KIND_PKG && !cfg_pend_q) begin
						res_valid = 1'b1;
						res.ev    = EV_DROP;
						res.ilen  = ilen;
					end else if (hdr_kind == KIND_UNK) begin
						res_valid = 1'b1;
						res.ev    = EV_UNKNOWN;
						res.ilen  = ilen;
					end else if (hdr_kind == KIND_NEG && rem_hdr == 11'd0) begin
						res_valid = 1'b1;
						res       = neg_result(8'd0, 8'd0);
					end
				end
			end
			PH_PAYLOAD: begin
				if (fwd_q) begin
					res_valid   = 1'b1;
					res.ev      = (kind_q == KIND_CFG) ? EV_CFG : EV_PKG;
					res.payload = data_byte;
					res.last    = fin;
				end else if (kind_q == KIND_NEG && byte_idx_q == 4'd0) begin
					res_valid = fin;
					res       = neg_result(data_byte, 8'd0);
				end else if (kind_q == KIND_NEG && byte_idx_q == 4'd1) begin
					res_valid = 1'b1;
					res       = neg_result(neg_b0_q, data_byte);
				end
			end
			default: ;
		endcase
		res_valid = res_valid & step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OUTER;
			byte_idx_q <= '0;
			len_lo_q   <= '0;
			len_hi_q   <= 1'b0;
			remain_q   <= '0;
			kind_q     <= '0;
			inner_b0_q <= '0;
			neg_b0_q   <= '0;
			cfg_pend_q <= 1'b0;
			fwd_q      <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_nxt;
			byte_idx_q <= byte_idx_nxt;
			len_lo_q   <= len_lo_nxt;
			len_hi_q   <= len_hi_nxt;
			remain_q   <= remain_nxt;
			kind_q     <= kind_nxt;
			inner_b0_q <= inner_b0_nxt;
			neg_b0_q   <= neg_b0_nxt;
			cfg_pend_q <= cfg_pend_nxt;
			fwd_q      <= fwd_nxt;
		end
	end

`ifndef SYNTHESIS
	a_inner_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_INNER |-> byte_idx_q <= 4'd1)
		else $error("inner header index out of range");
	a_payload_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> byte_idx_q <= 4'd2)
		else $error("payload index out of range");
	a_fwd_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.ev == EV_CFG || res.ev == EV_PKG) |-> fwd_q && phase_q == PH_PAYLOAD)
		else $error("forwarded byte outside a forwarding payload");
	a_hdr_to_payload: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_INNER && byte_idx_q == 4'd1 && rem_hdr != 11'd0
		|=> phase_q == PH_PAYLOAD)
		else $error("inner header did not enter payload");
`endif

endmodule
`default_nettype wire

/* hdl/lfd_out_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfd_out_buf
// Result register with one skid entry, so the parser can take one more step under stall.
// ----------------------------------------------------------------------------
module lfd_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lfd_pkg::res_t push_data,
	output logic               ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output lfd_pkg::res_t      out_data
);
	import lfd_pkg::*;

	logic out_valid_q;
	res_t out_data_q;
	logic skid_valid_q;
	res_t skid_data_q;

	assign ready     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule
`default_nettype wire

/* hdl/link_frame_deframer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// link_frame_deframer_unit
// Length-prefixed link frame deframer, one received byte per item.
// ----------------------------------------------------------------------------
// Slave stream s_*: one link byte per item in s_tdata. Master stream m_*: at
// most one result item per byte, event code in m_tuser, last payload byte of a
// forwarded frame on m_tlast, the remaining fields in m_tdata.
// cfg_we/cfg_wdata write the largest accepted outer payload length; write it
// only while the block is idle.
// A byte is registered in the input register on acceptance and parsed from
// there; its result, if any, is registered in the result register and then
// shows on m_tvalid. One byte per cycle is sustained while m_tready is high;
// the rate is set by the single parse step between the input and result registers.
// Reset (arst_n low) sets the length limit to 2032, clears the pending-config
// flag and makes the parser wait for an outer header.
// When m_tready is low the result register holds, one more result goes to a
// skid entry and one more byte waits in the input register; s_tready then
// drops until the master side drains.
// ----------------------------------------------------------------------------
module link_frame_deframer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,    // max_payload_length
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,      // data_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// payload_byte[7:0], neg_ack2[8], neg_pass[9], neg_reason[16:10],
	// inner_length[30:17], zero[31]
	output logic [31:0]      m_tdata,
	output logic [2:0]       m_tuser,      // event_res
	output logic             m_tlast       // last
);
	import lfd_pkg::*;

	logic [10:0] max_len_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        buf_ready;
	logic        step;
	logic        res_valid;
	res_t        res;
	res_t        out_res;

	assign step     = valid_s1 && buf_ready;
	assign s_tready = !valid_s1 || buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	lfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	lfd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.ready     (buf_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {1'b0, out_res.ilen, out_res.reason, out_res.pass, out_res.ack2,
		out_res.payload};
	assign m_tuser = out_res.ev;
	assign m_tlast = out_res.last;

endmodule
`default_nettype wire
